>>> sv/rpxf_pkg.sv
`default_nettype none
package rpxf_pkg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FADE,
        BK_MIX,
        BK_WET,
        BK_DONE
    } t_back_state;

    localparam int CFG_INDEX_BITS = 1;
    localparam int GAIN_BITS      = 17;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WET_MIX   = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FADE_STEP = 1'b1;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE        = 17'h10000;
    localparam logic [GAIN_BITS-1:0] WET_MIX_RESET   = 17'h10000;
    localparam logic [GAIN_BITS-1:0] FADE_STEP_RESET = 17'd137;

    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint Q30_ONE = 64'sd1073741824;

    // raised cosine for the first half of the table, q0.16, series in q2.30
    function automatic longint half_fade(input longint m, input int bits);
        longint a;
        longint a2;
        longint t;
        longint g;
        a  = (PI_Q30 * m) >>> bits;
        a2 = (a * a) / Q30_ONE;
        t  = Q30_ONE;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 132;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 90;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 56;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 30;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 12;
        t  = Q30_ONE - ((a2 * t) / Q30_ONE) / 2;
        g  = (Q30_ONE - t) / 2;
        g  = (g + 8192) / 16384;
        if (g < 0) begin
            g = 0;
        end
        if (g > 65536) begin
            g = 65536;
        end
        return g;
    endfunction

    function automatic logic [GAIN_BITS-1:0] fade_gain(input int k, input int bits);
        longint n;
        longint g;
        n = longint'(1) << bits;
        if (longint'(k) <= n / 2) begin
            g = half_fade(longint'(k), bits);
        end else begin
            g = 65536 - half_fade(n - longint'(k), bits);
        end
        return GAIN_BITS'(g);
    endfunction

endpackage
`default_nettype wire

>>> sv/reverse_playback_crossfade_top.sv
// Reverse delay effect with raised-cosine crossfade at each segment restart.
// Input stream (s_axis): one signed audio sample per beat in tdata. Output
// stream (m_axis): one mixed sample per input beat, in the same order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 = wet mix, 1 = fade step, both q1.16); write only while no sample is
// in flight.
// Input beats go into a four-entry queue holding the write/read indexes for
// each sample; popping a sample stores it and reads the store, then a
// back-end sequencer runs four steps: crossfade multiply, crossfade add,
// wet/dry multiply, output load. The shared multiplier and the four-step
// sequencer let the back end work on one sample at a time while the queue
// keeps taking beats; a beat reaches o_m_axis_tvalid after the four steps.
// When the receiver stalls, the output register holds its beat, the back end
// stops at its last step and the queue fills; o_s_axis_tready falls once
// four samples are queued.
// Reset (synchronous, active low) clears indexes, fade state and the held
// sample and loads the register defaults; the sample store is not cleared
// and needs no clearing pass, as reads only reach written entries.
`default_nettype none
module reverse_playback_crossfade_top #(
    parameter int BUFFER_DEPTH    = 131072,
    parameter int SAMPLE_BITS     = 24,
    parameter int FADE_TABLE_BITS = 10
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // sample_in
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // sample_out
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]    o_m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [rpxf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [rpxf_pkg::GAIN_BITS-1:0]      i_cfg_data
);

    localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ADDR_BITS  = $clog2(BUFFER_DEPTH);
    localparam int ENTRY_BITS = SAMPLE_BITS + 2 * ADDR_BITS + 2;

    logic                   w_push;
    logic [ENTRY_BITS-1:0]  w_push_data;
    logic                   w_full;
    logic                   w_pop;
    logic [ENTRY_BITS-1:0]  w_pop_data;
    logic                   w_empty;
    logic [SAMPLE_BITS-1:0] w_sample_out;

    rpxf_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_sample    (i_s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    rpxf_queue #(
        .WIDTH      (ENTRY_BITS),
        .DEPTH_BITS (2)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    rpxf_back #(
        .BUFFER_DEPTH    (BUFFER_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .FADE_TABLE_BITS (FADE_TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (w_empty),
        .i_q_data    (w_pop_data),
        .o_q_pop     (w_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_sample    (w_sample_out)
    );

    assign o_m_axis_tdata = DATA_BITS'(w_sample_out);

endmodule
`default_nettype wire

>>> sv/rpxf_ram.sv
`default_nettype none
module rpxf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 131072
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> sv/rpxf_queue.sv
`default_nettype none
module rpxf_queue #(
    parameter int WIDTH      = 60,
    parameter int DEPTH_BITS = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_pop_data,
    output logic                  o_empty
);

    localparam int DEPTH = 1 << DEPTH_BITS;

    logic [WIDTH-1:0]      r_slot [DEPTH];
    logic [DEPTH_BITS-1:0] r_wr_ptr;
    logic [DEPTH_BITS-1:0] r_rd_ptr;
    logic [DEPTH_BITS:0]   r_count;
    logic [DEPTH_BITS-1:0] n_wr_ptr;
    logic [DEPTH_BITS-1:0] n_rd_ptr;
    logic [DEPTH_BITS:0]   n_count;

    assign o_full     = (r_count == (DEPTH_BITS+1)'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + DEPTH_BITS'(i_push);
        n_rd_ptr = r_rd_ptr + DEPTH_BITS'(i_pop);
        n_count  = r_count + (DEPTH_BITS+1)'(i_push) - (DEPTH_BITS+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/rpxf_front.sv
`default_nettype none
module rpxf_front #(
    parameter int BUFFER_DEPTH = 131072,
    parameter int SAMPLE_BITS  = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_full,
    output logic                        o_push,
    output logic [SAMPLE_BITS+2*$clog2(BUFFER_DEPTH)+1:0] o_push_data
);

    localparam int ADDR_BITS = $clog2(BUFFER_DEPTH);
    localparam logic [ADDR_BITS-1:0] LAST_INDEX = ADDR_BITS'(BUFFER_DEPTH - 1);

    logic [ADDR_BITS-1:0] r_wr_index;
    logic [ADDR_BITS-1:0] r_rd_index;
    logic [ADDR_BITS-1:0] n_wr_index;
    logic [ADDR_BITS-1:0] n_rd_index;
    logic                 w_restart;
    logic                 w_hit;

    assign o_ready   = !i_full;
    assign o_push    = i_valid && !i_full;
    // read index hits zero: segment ends and reading restarts at this write slot
    assign w_restart = (r_rd_index == '0);
    // reading the slot written by this same beat
    assign w_hit     = (r_rd_index == r_wr_index);

    // entry layout from lsb: sample, write index, read index, restart, hit
    assign o_push_data = {w_hit, w_restart, r_rd_index, r_wr_index, i_sample};

    always_comb begin
        n_wr_index = (r_wr_index == LAST_INDEX) ? '0 : r_wr_index + ADDR_BITS'(1);
        n_rd_index = w_restart ? r_wr_index : r_rd_index - ADDR_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_index <= '0;
            r_rd_index <= '0;
        end else if (o_push) begin
            r_wr_index <= n_wr_index;
            r_rd_index <= n_rd_index;
        end
    end

endmodule
`default_nettype wire

>>> sv/rpxf_back.sv
`default_nettype none
module rpxf_back #(
    parameter int BUFFER_DEPTH    = 131072,
    parameter int SAMPLE_BITS     = 24,
    parameter int FADE_TABLE_BITS = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [rpxf_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [rpxf_pkg::GAIN_BITS-1:0]         i_cfg_data,
    input  wire logic                                   i_q_empty,
    input  wire logic [SAMPLE_BITS+2*$clog2(BUFFER_DEPTH)+1:0] i_q_data,
    output logic                                        o_q_pop,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic      [SAMPLE_BITS-1:0]                 o_sample
);

    localparam int ADDR_BITS = $clog2(BUFFER_DEPTH);
    localparam int SB        = SAMPLE_BITS;
    localparam int GB        = rpxf_pkg::GAIN_BITS;
    localparam int PW        = SB + 1 + GB + 1;
    localparam int FADE_N    = 1 << FADE_TABLE_BITS;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);
    localparam logic signed [SB+1:0] SAT_HI = (SB+2)'((longint'(1) << (SB - 1)) - 1);
    localparam logic signed [SB+1:0] SAT_LO = -(SB+2)'(longint'(1) << (SB - 1));

    // fade gain table, built at elaboration
    logic [GB-1:0] w_rom [FADE_N];
    for (genvar k = 0; k < FADE_N; k++) begin : g_rom
        assign w_rom[k] = rpxf_pkg::fade_gain(k, FADE_TABLE_BITS);
    end

    rpxf_pkg::t_back_state r_state;
    rpxf_pkg::t_back_state n_state;

    logic [GB-1:0]        r_wet_mix;
    logic [GB-1:0]        r_fade_step;
    logic [GB-1:0]        r_phase;
    logic signed [SB-1:0] r_held;
    logic [GB-1:0]        r_gain;
    logic signed [SB-1:0] r_x;
    logic                 r_restart;
    logic                 r_hit;
    logic signed [SB-1:0] r_rev;
    logic signed [PW-1:0] r_prod;
    logic                 r_valid;
    logic signed [SB-1:0] r_sample;

    logic                 w_out_free;
    logic                 w_pop;
    logic                 w_load_out;
    logic                 w_fading;
    logic [SB-1:0]        w_ram_rdata;
    logic signed [SB-1:0] w_rev_raw;
    logic signed [SB:0]   w_mul_a;
    logic signed [GB:0]   w_mul_b;
    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] w_shift;
    logic signed [SB:0]   w_fade_ext;
    logic signed [SB-1:0] w_rev_fade;
    logic signed [SB+1:0] w_mix_ext;
    logic signed [SB-1:0] w_mix_sat;
    logic [GB-1:0]        w_wet;
    logic [GB:0]          w_phase_sum;
    logic [GB-1:0]        w_phase_adv;

    logic [SB-1:0]        w_q_sample;
    logic [ADDR_BITS-1:0] w_q_wr_index;
    logic [ADDR_BITS-1:0] w_q_rd_index;
    logic                 w_q_restart;
    logic                 w_q_hit;

    assign w_q_sample   = i_q_data[SB-1:0];
    assign w_q_wr_index = i_q_data[SB +: ADDR_BITS];
    assign w_q_rd_index = i_q_data[SB+ADDR_BITS +: ADDR_BITS];
    assign w_q_restart  = i_q_data[SB+2*ADDR_BITS];
    assign w_q_hit      = i_q_data[SB+2*ADDR_BITS+1];

    rpxf_ram #(
        .WIDTH (SB),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_pop),
        .i_waddr (w_q_wr_index),
        .i_wdata (w_q_sample),
        .i_raddr (w_q_rd_index),
        .o_rdata (w_ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpxf_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = rpxf_pkg::BK_FADE;
                end
            end
            rpxf_pkg::BK_FADE: n_state = rpxf_pkg::BK_MIX;
            rpxf_pkg::BK_MIX:  n_state = rpxf_pkg::BK_WET;
            rpxf_pkg::BK_WET:  n_state = rpxf_pkg::BK_DONE;
            rpxf_pkg::BK_DONE: begin
                if (w_out_free) begin
                    n_state = i_q_empty ? rpxf_pkg::BK_IDLE : rpxf_pkg::BK_FADE;
                end
            end
            default: n_state = rpxf_pkg::BK_IDLE;
        endcase
    end

    // state decode
    always_comb begin
        w_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            rpxf_pkg::BK_IDLE: w_pop = !i_q_empty;
            rpxf_pkg::BK_DONE: begin
                w_load_out = w_out_free;
                w_pop      = w_out_free && !i_q_empty;
            end
            default: begin
                w_pop      = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    assign o_q_pop    = w_pop;
    assign w_out_free = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_sample   = r_sample;

    assign w_fading  = !r_phase[GB-1];
    assign w_wet     = r_wet_mix[GB-1] ? rpxf_pkg::GAIN_ONE : r_wet_mix;
    assign w_rev_raw = r_hit ? r_x : signed'(w_ram_rdata);

    // one shared multiplier: crossfade step, then wet/dry step
    always_comb begin
        if (r_state == rpxf_pkg::BK_FADE) begin
            w_mul_a = (SB+1)'(w_rev_raw) - (SB+1)'(r_held);
            w_mul_b = signed'({1'b0, r_gain});
        end else begin
            w_mul_a = (SB+1)'(r_rev) - (SB+1)'(r_x);
            w_mul_b = signed'({1'b0, w_wet});
        end
        w_prod = w_mul_a * w_mul_b;
    end

    // base + floor((diff*gain + half) / 65536)
    assign w_shift    = (r_prod + ROUND_HALF) >>> 16;
    assign w_fade_ext = (SB+1)'(r_held) + w_shift[SB:0];
    assign w_rev_fade = w_fading ? w_fade_ext[SB-1:0] : r_rev;
    assign w_mix_ext  = (SB+2)'(r_x) + w_shift[SB+1:0];

    always_comb begin
        if (w_mix_ext > SAT_HI) begin
            w_mix_sat = SAT_HI[SB-1:0];
        end else if (w_mix_ext < SAT_LO) begin
            w_mix_sat = SAT_LO[SB-1:0];
        end else begin
            w_mix_sat = w_mix_ext[SB-1:0];
        end
    end

    assign w_phase_sum = {1'b0, r_phase} + {1'b0, r_fade_step};
    assign w_phase_adv = (w_phase_sum > {1'b0, rpxf_pkg::GAIN_ONE}) ?
                         rpxf_pkg::GAIN_ONE : w_phase_sum[GB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpxf_pkg::BK_IDLE;
            r_wet_mix   <= rpxf_pkg::WET_MIX_RESET;
            r_fade_step <= rpxf_pkg::FADE_STEP_RESET;
            r_phase     <= rpxf_pkg::GAIN_ONE;
            r_held      <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rpxf_pkg::CFG_WET_MIX:   r_wet_mix   <= i_cfg_data;
                    rpxf_pkg::CFG_FADE_STEP: r_fade_step <= i_cfg_data;
                    default: r_wet_mix <= r_wet_mix;
                endcase
            end
            if (r_state == rpxf_pkg::BK_MIX) begin
                if (r_restart) begin
                    r_held  <= w_rev_fade;
                    r_phase <= '0;
                end else if (w_fading) begin
                    r_phase <= w_phase_adv;
                end
            end
            if (w_load_out) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain <= w_rom[r_phase[GB-2 -: FADE_TABLE_BITS]];
        if (w_pop) begin
            r_x       <= signed'(w_q_sample);
            r_restart <= w_q_restart;
            r_hit     <= w_q_hit;
        end
        if (r_state == rpxf_pkg::BK_FADE) begin
            r_rev  <= w_rev_raw;
            r_prod <= w_prod;
        end
        if (r_state == rpxf_pkg::BK_MIX) begin
            r_rev <= w_rev_fade;
        end
        if (r_state == rpxf_pkg::BK_WET) begin
            r_prod <= w_prod;
        end
        if (w_load_out) begin
            r_sample <= w_mix_sat;
        end
    end

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps

// predicts the reversed, crossfaded and mixed sample for every input beat
class reverse_echo_scoreboard;
    localparam int MEM_DEPTH = 131072;
    localparam int TBL_BITS  = 10;
    localparam int TBL_SIZE  = 1 << TBL_BITS;
    localparam longint UNITY = 65536;
    localparam longint Q30   = 64'sd1073741824;
    localparam longint PI_30 = 64'sd3373259426;

    logic signed [23:0] sample_mem [MEM_DEPTH];
    logic [16:0]        wr_ptr;
    logic [16:0]        rd_ptr;
    int unsigned        fade_pos;
    longint             held;
    logic [16:0]        wet_mix;
    logic [16:0]        fade_step;
    int                 fade_tbl [TBL_SIZE];
    logic [23:0]        expected_q [$];
    int                 errors;

    function new();
        wr_ptr    = '0;
        rd_ptr    = '0;
        fade_pos  = UNITY;
        held      = 0;
        wet_mix   = rpxf_pkg::WET_MIX_RESET;
        fade_step = rpxf_pkg::FADE_STEP_RESET;
        errors    = 0;
        // second half of the ramp mirrors the first
        for (int k = 0; k < TBL_SIZE; k++) begin
            if (k <= TBL_SIZE / 2) begin
                fade_tbl[k] = cos_ramp_q16(k);
            end else begin
                fade_tbl[k] = 65536 - cos_ramp_q16(TBL_SIZE - k);
            end
        end
    endfunction

    // 0.5 - 0.5*cos(pi*m/size) via truncated taylor series in q2.30
    function int cos_ramp_q16(longint m);
        longint ang;
        longint ang2;
        longint term;
        longint g;
        longint divisor [6];
        divisor = '{132, 90, 56, 30, 12, 2};
        ang  = (PI_30 * m) / TBL_SIZE;
        ang2 = (ang * ang) / Q30;
        term = Q30;
        foreach (divisor[i]) begin
            term = Q30 - ((ang2 * term) / Q30) / divisor[i];
        end
        g = (Q30 - term) / 2;
        g = (g + 8192) / 16384;
        if (g < 0) begin
            g = 0;
        end
        if (g > UNITY) begin
            g = UNITY;
        end
        return int'(g);
    endfunction

    function void set_reg(logic [rpxf_pkg::CFG_INDEX_BITS-1:0] idx,
                          logic [rpxf_pkg::GAIN_BITS-1:0] val);
        case (idx)
            rpxf_pkg::CFG_WET_MIX:   wet_mix = val;
            rpxf_pkg::CFG_FADE_STEP: fade_step = val;
            default: ;
        endcase
    endfunction

    function void note_sample(logic [23:0] raw);
        longint x;
        longint w;
        longint g;
        longint rev;
        longint mixed;
        x = longint'($signed(raw));
        w = (wet_mix > rpxf_pkg::GAIN_ONE) ? UNITY : longint'(wet_mix);
        sample_mem[wr_ptr] = raw;
        rev = longint'(sample_mem[rd_ptr]);
        if (fade_pos < UNITY) begin
            g   = fade_tbl[(fade_pos >> (16 - TBL_BITS)) & (TBL_SIZE - 1)];
            rev = (held * (UNITY - g) + rev * g + 32768) >>> 16;
            fade_pos = fade_pos + fade_step;
            if (fade_pos > UNITY) begin
                fade_pos = UNITY;
            end
        end
        // segment restart: freeze the current value and jump to the newest entry
        if (rd_ptr == 0) begin
            held     = rev;
            rd_ptr   = wr_ptr;
            fade_pos = 0;
        end else begin
            rd_ptr = rd_ptr - 1'b1;
        end
        mixed = (x * (UNITY - w) + rev * w + 32768) >>> 16;
        if (mixed > 64'sd8388607) begin
            mixed = 64'sd8388607;
        end else if (mixed < -64'sd8388608) begin
            mixed = -64'sd8388608;
        end
        expected_q.push_back(mixed[23:0]);
        wr_ptr = wr_ptr + 1'b1;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("%0d ns: %s", $time, what);
    endtask

    task check_result(logic [23:0] got);
        logic [23:0] want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected output beat %06h", got));
        end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("sample_out %06h, predicted %06h", got, want));
            end
        end
    endtask

    task drain_check();
        if (expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d output beats never arrived", expected_q.size()));
        end
    endtask
endclass

module tb;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic [23:0]                         s_tdata   = '0;
    logic                                m_tready  = 1'b0;
    logic                                cfg_we    = 1'b0;
    logic [rpxf_pkg::CFG_INDEX_BITS-1:0] cfg_index = rpxf_pkg::CFG_WET_MIX;
    logic [rpxf_pkg::GAIN_BITS-1:0]      cfg_data  = '0;
    wire                                 s_tready;
    wire                                 m_tvalid;
    wire  [23:0]                         m_tdata;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_hold    = 0;

    reverse_echo_scoreboard sb;

    reverse_playback_crossfade_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver backpressure in bursts of random length
    always @(negedge clk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    task automatic send_sample(input logic [23:0] v);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        sb.note_sample(v);
    endtask

    // stop sending and wait for every predicted beat to come out
    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rpxf_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [rpxf_pkg::GAIN_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return $urandom_range(0, 3) == 0 ? 24'h000000 : 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic run_setting(input logic [rpxf_pkg::GAIN_BITS-1:0] wet,
                               input logic [rpxf_pkg::GAIN_BITS-1:0] step,
                               input int count);
        quiesce();
        write_reg(rpxf_pkg::CFG_WET_MIX, wet);
        write_reg(rpxf_pkg::CFG_FADE_STEP, step);
        repeat (count) send_sample(pick_sample());
    endtask

    initial begin
        logic [23:0] corner [20];
        corner = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
                   24'h555555, 24'hAAAAAA, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                   24'h800000, 24'h123456, 24'hFEDCBA, 24'h400000, 24'hC00000,
                   24'h3FFFFF, 24'h800001, 24'h7FFFFE, 24'h000000, 24'h7FFFFF};
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults straight out of reset
        foreach (corner[i]) send_sample(corner[i]);

        run_setting(17'd0, 17'd65536, 150);
        run_setting(17'd32768, 17'd1, 200);
        run_setting(17'h1FFFF, 17'h1FFFF, 150);
        // fade never advances with a zero step
        run_setting(17'd65536, 17'd0, 100);
        quiesce();
        repeat (100) send_sample(pick_sample());

        run_setting(17'($urandom_range(0, 65536)), 17'($urandom_range(1, 65536)), 200);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_setting(17'($urandom_range(0, 65536)), 17'($urandom_range(1, 2048)), 200);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_setting(17'($urandom_range(0, 65536)), 17'($urandom_range(1, 65536)), 200);
        run_setting(17'd65536, 17'd137, 200);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_setting(17'($urandom_range(0, 65536)), 17'($urandom_range(1, 600)), 250);

        quiesce();
        repeat (20) @(posedge clk);
        sb.drain_check();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> reverse_playback_crossfade_top.f
sv/rpxf_pkg.sv
sv/rpxf_ram.sv
sv/rpxf_queue.sv
sv/rpxf_front.sv
sv/rpxf_back.sv
sv/reverse_playback_crossfade_top.sv
dv/tb.sv
